// ===== sv/tpf_pkg.sv =====
// shared types and constants for the tcp port packet filter
package tpf_pkg;

  // payload widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned CAP_W   = 11;
  localparam int unsigned HW_W    = 4;
  localparam int unsigned TCPS_W  = 8;

  // frame layout
  localparam logic [OFS_W-1:0]  OFS_ETYPE_HI = 16'd12;
  localparam logic [OFS_W-1:0]  OFS_ETYPE_LO = 16'd13;
  localparam logic [OFS_W-1:0]  OFS_IHL      = 16'd14;
  localparam logic [OFS_W-1:0]  OFS_PROTO    = 16'd23;
  localparam logic [OFS_W-1:0]  OFS_MAX      = 16'hFFFF;
  localparam logic [TCPS_W-1:0] ETH_HDR_LEN  = 8'd14;
  localparam logic [TCPS_W-1:0] TCP_MIN_LEN  = 8'd20;
  localparam logic [LEN_W-1:0]  MIN_IP_FRAME = 17'd34;

  // header codes
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [PORT_W-1:0] PORT_RESET = 16'd80;

  // queue between parser and output stage
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // per-frame verdict handed from the parser to the output stage
  typedef struct packed {
    logic              hdr_ok;
    logic [PORT_W-1:0] src_port;
    logic [CAP_W-1:0]  cap_len;
  } tpf_verdict_t;

endpackage

// ===== sv/tpf_ifs.sv =====
// channel interfaces: frame bytes in, verdicts out, port register writes

interface tpf_in_if;
  logic                       valid;
  logic                       ready;
  logic [tpf_pkg::BYTE_W-1:0] data_byte;
  logic                       frame_end;
  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface tpf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [tpf_pkg::CAP_W-1:0] capture_length;
  modport source (output valid, accepted, capture_length, input ready);
  modport sink   (input valid, accepted, capture_length, output ready);
endinterface

interface tpf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tpf_pkg::PORT_W-1:0] match_port;
  modport source (output valid, match_port, input ready);
  modport sink   (input valid, match_port, output ready);
endinterface

// ===== sv/tpf_parse.sv =====
// front end: walks the frame bytes, captures header fields, builds the verdict
module tpf_parse #(
  parameter int unsigned CAPTURE_LIMIT = 1500
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_valid,
  output logic                       byte_ready,
  input  logic [tpf_pkg::BYTE_W-1:0] data_byte,
  input  logic                       frame_end,
  output logic                       vrd_valid,
  input  logic                       vrd_ready,
  output tpf_pkg::tpf_verdict_t      vrd
);
  import tpf_pkg::*;

  localparam logic [LEN_W-1:0] CAP_LIM = LEN_W'(CAPTURE_LIMIT);

  logic [OFS_W-1:0]  byte_offset_r,  byte_offset_nxt;
  logic [15:0]       ether_type_r,   ether_type_nxt;
  logic [HW_W-1:0]   header_words_r, header_words_nxt;
  logic [7:0]        ip_protocol_r,  ip_protocol_nxt;
  logic [PORT_W-1:0] source_port_r,  source_port_nxt;

  logic              take;
  logic [TCPS_W-1:0] tcp_start;
  logic [TCPS_W-1:0] tcp_end;
  logic [LEN_W-1:0]  frame_len;
  logic [LEN_W-1:0]  clip_len;

  // every byte waits while a verdict could not be queued, closing byte or not
  assign byte_ready = vrd_ready;
  assign take       = byte_valid && byte_ready;

  // field capture, header length bypassed so a zero length hits byte 14
  always_comb begin
    ether_type_nxt   = ether_type_r;
    header_words_nxt = header_words_r;
    ip_protocol_nxt  = ip_protocol_r;
    source_port_nxt  = source_port_r;
    if (byte_offset_r == OFS_ETYPE_HI) begin
      ether_type_nxt[15:8] = data_byte;
    end else if (byte_offset_r == OFS_ETYPE_LO) begin
      ether_type_nxt[7:0] = data_byte;
    end
    if (byte_offset_r == OFS_IHL) begin
      header_words_nxt = data_byte[HW_W-1:0];
    end
    if (byte_offset_r == OFS_PROTO) begin
      ip_protocol_nxt = data_byte;
    end
    tcp_start = ETH_HDR_LEN + {2'b00, header_words_nxt, 2'b00};
    if (byte_offset_r == OFS_W'(tcp_start)) begin
      source_port_nxt[15:8] = data_byte;
    end else if (byte_offset_r == OFS_W'(tcp_start) + OFS_W'(1)) begin
      source_port_nxt[7:0] = data_byte;
    end
    tcp_end = tcp_start + TCP_MIN_LEN;
  end

  // saturating byte counter
  assign byte_offset_nxt = (byte_offset_r == OFS_MAX) ? byte_offset_r
                                                      : byte_offset_r + OFS_W'(1);

  // verdict for the closing byte
  assign frame_len = {1'b0, byte_offset_r} + LEN_W'(1);
  assign clip_len  = (frame_len > CAP_LIM) ? CAP_LIM : frame_len;

  always_comb begin
    vrd.hdr_ok   = (frame_len >= MIN_IP_FRAME)
                && (LEN_W'(tcp_end) <= frame_len)
                && (ether_type_nxt == ETHERTYPE_IPV4)
                && (ip_protocol_nxt == PROTO_TCP);
    vrd.src_port = source_port_nxt;
    vrd.cap_len  = clip_len[CAP_W-1:0];
  end

  assign vrd_valid = byte_valid && frame_end;

  // frame state, cleared after every frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r  <= '0;
      ether_type_r   <= '0;
      header_words_r <= '0;
      ip_protocol_r  <= '0;
      source_port_r  <= '0;
    end else if (take) begin
      if (frame_end) begin
        byte_offset_r  <= '0;
        ether_type_r   <= '0;
        header_words_r <= '0;
        ip_protocol_r  <= '0;
        source_port_r  <= '0;
      end else begin
        byte_offset_r  <= byte_offset_nxt;
        ether_type_r   <= ether_type_nxt;
        header_words_r <= header_words_nxt;
        ip_protocol_r  <= ip_protocol_nxt;
        source_port_r  <= source_port_nxt;
      end
    end
  end

endmodule

// ===== sv/tpf_queue.sv =====
// short verdict queue between the parser and the output stage
module tpf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  tpf_pkg::tpf_verdict_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output tpf_pkg::tpf_verdict_t pop_data
);
  import tpf_pkg::*;

  tpf_verdict_t     slot_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (Q_AW+1)'(1);
      end
    end
  end

endmodule

// ===== sv/tpf_emit.sv =====
// back end: port match against the register and the output holding stage
module tpf_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vrd_valid,
  output logic                       vrd_ready,
  input  tpf_pkg::tpf_verdict_t      vrd,
  input  logic                       cfg_valid,
  input  logic [tpf_pkg::PORT_W-1:0] cfg_port,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       accepted,
  output logic [tpf_pkg::CAP_W-1:0]  capture_length
);
  import tpf_pkg::*;

  logic [PORT_W-1:0] match_port_r;
  logic              out_valid_r;
  logic              accepted_r;
  logic [CAP_W-1:0]  capture_length_r;
  logic              load;

  // port register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r <= PORT_RESET;
    end else if (cfg_valid) begin
      match_port_r <= cfg_port;
    end
  end

  // take a verdict whenever the holding stage is free or draining
  assign vrd_ready = !out_valid_r || res_ready;
  assign load      = vrd_valid && vrd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (vrd_ready) begin
      out_valid_r <= vrd_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      accepted_r       <= vrd.hdr_ok && (vrd.src_port == match_port_r);
      capture_length_r <= vrd.cap_len;
    end
  end

  assign res_valid      = out_valid_r;
  assign accepted       = accepted_r;
  assign capture_length = capture_length_r;

endmodule

// ===== sv/tcp_port_packet_filter.sv =====
// top level of the ethernet ipv4 tcp source port filter
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | data_byte[7:0], frame_end
//  out_ch   | out | valid/ready   | accepted, capture_length[10:0]
//  cfg_ch   | in  | valid/ready   | match_port[15:0]
//
// one byte is taken every cycle while in_ch.ready is high. the verdict of a
// closing byte is written into the verdict queue, then into the output
// register of the match stage. reset (rst_n low, synchronous) empties the
// queue, the output register and the frame state and sets match_port to 80.
// a stalled output holds its result; two more verdicts queue behind it, then
// in_ch.ready drops until the output drains. cfg_ch is always ready.
module tcp_port_packet_filter #(
  parameter int unsigned CAPTURE_LIMIT = 1500
) (
  input  logic             clk,
  input  logic             rst_n,
  tpf_in_if.sink           in_ch,
  tpf_out_if.source        out_ch,
  tpf_cfg_if.sink          cfg_ch
);
  import tpf_pkg::*;

  tpf_verdict_t vrd_push, vrd_pop;
  logic         push_valid, push_ready;
  logic         pop_valid, pop_ready;

  assign cfg_ch.ready = 1'b1;

  // byte parser
  tpf_parse #(
    .CAPTURE_LIMIT (CAPTURE_LIMIT)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_ready (in_ch.ready),
    .data_byte  (in_ch.data_byte),
    .frame_end  (in_ch.frame_end),
    .vrd_valid  (push_valid),
    .vrd_ready  (push_ready),
    .vrd        (vrd_push)
  );

  // verdict queue
  tpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (vrd_push),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (vrd_pop)
  );

  // match and output stage
  tpf_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .vrd_valid      (pop_valid),
    .vrd_ready      (pop_ready),
    .vrd            (vrd_pop),
    .cfg_valid      (cfg_ch.valid),
    .cfg_port       (cfg_ch.match_port),
    .res_valid      (out_ch.valid),
    .res_ready      (out_ch.ready),
    .accepted       (out_ch.accepted),
    .capture_length (out_ch.capture_length)
  );

endmodule

// ===== sv/tpf_checker.sv =====
// port-level checks for the filter, bound to the top level
module tpf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_frame_end,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_accepted,
  input logic [tpf_pkg::CAP_W-1:0] out_capture_length
);
  import tpf_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_accepted) && $stable(out_capture_length))
    else $error("result changed while stalled");

  // nothing is offered straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // from an empty pipe a result rises only after a frame end was taken and its verdict passed the queue
  a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_frame_end, 2))
    else $error("result without a closing item");

endmodule

bind tcp_port_packet_filter tpf_checker u_tpf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_frame_end       (in_ch.frame_end),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_accepted       (out_ch.accepted),
  .out_capture_length (out_ch.capture_length)
);
